/* rtl/mrfdf_pkg.sv */
package mrfdf_pkg;

    localparam int HEADER_BITS     = 16;
    localparam int MAX_FRAME_BYTES = 2048;

    localparam logic [15:0] CRC16_POLY = 16'h1021;
    localparam logic [31:0] CRC32_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC32_INIT = 32'hFFFFFFFF;
    localparam logic [8:0]  PN9_SEED   = 9'h1FF;

    localparam logic [1:0] STATUS_BUSY    = 2'd0;
    localparam logic [1:0] STATUS_OK      = 2'd1;
    localparam logic [1:0] STATUS_FAIL    = 2'd2;
    localparam logic [1:0] STATUS_OVERRUN = 2'd3;

    typedef struct packed {
        logic data_bit;
        logic sync_flag;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  byte_value;
        logic [10:0] byte_index;
        logic [15:0] header_word;
        logic        is_last;
        logic [1:0]  frame_status;
    } t_out_item;

    typedef struct packed {
        logic        load16;
        logic        load32;
        logic        step16;
        logic        step32;
        logic        data_bit;
        logic [15:0] seed;
    } t_crc_ctrl;

endpackage

/* rtl/mrfsk_frame_deframer.sv */
// MR-FSK frame deframer: one received bit per input transaction, with the
// correlator sync flag, and one output transaction per finished payload byte.
// Both channels use valid and stall; a transaction completes on a clock edge
// with valid high and stall low. The input stall is low while the sequencer
// is idle, so a bit that does not complete a byte leaves the input ready.
// A bit that completes a payload byte starts the bit-serial sequencer: PN9
// dewhitening when whitening is on, a bitwise CRC update (cut short when the
// byte lies outside the CRC-32 span), a bookkeeping step, up to 32 bits of
// zero padding at the end of a short CRC-32 frame, and a step that loads the
// output register. The shared CRC unit takes one bit per cycle.
// The CRC-16 seed register r_seed is written with i_cfg_we and i_cfg_data;
// the user must write it only while idle, as the block does not enforce it.
// A result waits in the output register while the receiver stalls; the block
// keeps accepting bits meanwhile. Its input stalls while the sequencer runs,
// and also while the next byte is ready and the output register is still occupied.
// Reset is synchronous and active low; it returns the block to sync search
// with an empty output register and a zero seed.
module mrfsk_frame_deframer (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  mrfdf_pkg::t_in_item  i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output mrfdf_pkg::t_out_item o_out_item,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data
);
    import mrfdf_pkg::*;

    localparam logic [1:0] PH_SEARCH  = 2'd0;
    localparam logic [1:0] PH_HEADER  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WHITE = 3'd1;
    localparam logic [2:0] ST_CRC   = 3'd2;
    localparam logic [2:0] ST_POST  = 3'd3;
    localparam logic [2:0] ST_PAD   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]  r_state;
    logic [1:0]  r_phase;
    logic [15:0] r_header;
    logic [4:0]  r_hdr_cnt;
    logic [7:0]  r_byte;
    logic [2:0]  r_bit_cnt;
    logic [11:0] r_bytes_rx;
    logic [8:0]  r_lfsr;
    logic [31:0] r_tail;
    logic [2:0]  r_step;
    logic        r_crc32_on;
    logic [5:0]  r_pad;
    logic [10:0] r_idx;
    logic        r_last;
    logic [1:0]  r_status;
    logic        r_need_cmp;
    logic [15:0] r_seed;
    logic        r_out_valid;
    t_out_item   r_out_item;

    logic        w_accept;
    logic        w_bit;
    logic [10:0] w_len;
    logic        w_dw;
    logic        w_fcs16;
    logic [15:0] w_hdr_next;
    logic [4:0]  w_hdr_cnt_next;
    logic [11:0] w_cnt_next;
    logic        w_out_free;
    logic [15:0] w_crc16;
    logic [31:0] w_crc32;
    t_crc_ctrl   w_ctrl;

    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_bit      = i_in_item.data_bit;
    assign w_len      = r_header[10:0];
    assign w_dw       = r_header[11];
    assign w_fcs16    = r_header[12];
    assign w_hdr_next = {r_header[14:0], w_bit};
    assign w_hdr_cnt_next = r_hdr_cnt + 5'd1;
    assign w_cnt_next = r_bytes_rx + 12'd1;
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        w_ctrl          = '0;
        w_ctrl.seed     = r_seed;
        w_ctrl.data_bit = 1'b0;
        if (w_accept && r_phase == PH_HEADER
                && w_hdr_cnt_next == 5'(HEADER_BITS)) begin
            w_ctrl.load16 = w_hdr_next[12];
            w_ctrl.load32 = !w_hdr_next[12];
        end
        if (r_state == ST_CRC) begin
            w_ctrl.step16   = w_fcs16;
            w_ctrl.step32   = !w_fcs16 && r_crc32_on;
            w_ctrl.data_bit = w_fcs16 ? r_byte[3'd7 - r_step] : r_byte[r_step];
        end
        if (r_state == ST_PAD) begin
            w_ctrl.step32 = 1'b1;
        end
    end

    mrfdf_crc_unit u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .o_crc16 (w_crc16),
        .o_crc32 (w_crc32)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= PH_SEARCH;
            r_header    <= 16'd0;
            r_hdr_cnt   <= 5'd0;
            r_byte      <= 8'd0;
            r_bit_cnt   <= 3'd0;
            r_bytes_rx  <= 12'd0;
            r_lfsr      <= PN9_SEED;
            r_tail      <= 32'd0;
            r_step      <= 3'd0;
            r_crc32_on  <= 1'b0;
            r_pad       <= 6'd0;
            r_seed      <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
            end
            if (r_state == ST_EMIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        if (r_phase == PH_HEADER) begin
                            r_header  <= w_hdr_next;
                            r_hdr_cnt <= w_hdr_cnt_next;
                            if (w_hdr_cnt_next == 5'(HEADER_BITS)) begin
                                if (w_hdr_next[11]) begin
                                    r_lfsr <= PN9_SEED;
                                end
                                r_phase    <= PH_PAYLOAD;
                                r_bit_cnt  <= 3'd0;
                                r_byte     <= 8'd0;
                                r_bytes_rx <= 12'd0;
                                r_tail     <= 32'd0;
                            end
                        end else if (r_phase == PH_PAYLOAD) begin
                            r_byte    <= {r_byte[6:0], w_bit};
                            r_bit_cnt <= r_bit_cnt + 3'd1;
                            if (r_bit_cnt == 3'd7) begin
                                r_step     <= 3'd0;
                                r_crc32_on <= ({1'b0, r_bytes_rx} + 13'd4) < {2'b00, w_len};
                                if (w_dw) begin
                                    r_state <= ST_WHITE;
                                end else begin
                                    r_state <= ST_CRC;
                                end
                            end
                        end else begin
                            if (i_in_item.sync_flag) begin
                                r_header  <= {15'd0, w_bit};
                                r_hdr_cnt <= 5'd1;
                                r_phase   <= PH_HEADER;
                            end else begin
                                r_phase <= PH_SEARCH;
                            end
                        end
                    end
                end
                ST_WHITE: begin
                    r_byte <= {r_byte[6:0], r_byte[7] ^ r_lfsr[0]};
                    r_lfsr <= {r_lfsr[0] ^ r_lfsr[5], r_lfsr[8:1]};
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7) begin
                        r_state <= ST_CRC;
                    end
                end
                ST_CRC: begin
                    r_step <= r_step + 3'd1;
                    if (r_step == 3'd7 || (!w_fcs16 && !r_crc32_on)) begin
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    r_tail     <= {r_tail[23:0], r_byte};
                    r_idx      <= r_bytes_rx[10:0];
                    r_bytes_rx <= w_cnt_next;
                    if (w_cnt_next >= {1'b0, w_len}) begin
                        r_last  <= 1'b1;
                        r_phase <= PH_SEARCH;
                        if (w_fcs16) begin
                            r_status   <= (w_crc16 == 16'd0) ? STATUS_OK : STATUS_FAIL;
                            r_need_cmp <= 1'b0;
                            r_state    <= ST_EMIT;
                        end else if (w_len < 11'd4) begin
                            r_status   <= STATUS_FAIL;
                            r_need_cmp <= 1'b0;
                            r_state    <= ST_EMIT;
                        end else begin
                            r_status   <= STATUS_BUSY;
                            r_need_cmp <= 1'b1;
                            if (w_cnt_next < 12'd8) begin
                                r_pad   <= {3'(4'd8 - {1'b0, w_cnt_next[2:0]}), 3'b000};
                                r_state <= ST_PAD;
                            end else begin
                                r_state <= ST_EMIT;
                            end
                        end
                    end else if (w_cnt_next >= 12'(MAX_FRAME_BYTES)) begin
                        r_last     <= 1'b1;
                        r_status   <= STATUS_OVERRUN;
                        r_need_cmp <= 1'b0;
                        r_phase    <= PH_SEARCH;
                        r_state    <= ST_EMIT;
                    end else begin
                        r_last     <= 1'b0;
                        r_status   <= STATUS_BUSY;
                        r_need_cmp <= 1'b0;
                        r_state    <= ST_EMIT;
                    end
                end
                ST_PAD: begin
                    r_pad <= r_pad - 6'd1;
                    if (r_pad == 6'd1) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free) begin
            r_out_item.byte_value  <= r_byte;
            r_out_item.byte_index  <= r_idx;
            r_out_item.header_word <= r_header;
            r_out_item.is_last     <= r_last;
            if (r_need_cmp) begin
                r_out_item.frame_status <= (~w_crc32 == r_tail) ? STATUS_OK : STATUS_FAIL;
            end else begin
                r_out_item.frame_status <= r_status;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* rtl/mrfdf_crc_unit.sv */
module mrfdf_crc_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mrfdf_pkg::t_crc_ctrl i_ctrl,
    output logic [15:0]         o_crc16,
    output logic [31:0]         o_crc32
);
    import mrfdf_pkg::*;

    logic [15:0] r_crc16;
    logic [15:0] n_crc16;
    logic [31:0] r_crc32;
    logic [31:0] n_crc32;
    logic        w_fb16;
    logic        w_fb32;

    assign w_fb16 = r_crc16[15] ^ i_ctrl.data_bit;
    assign w_fb32 = r_crc32[0] ^ i_ctrl.data_bit;

    always_comb begin
        n_crc16 = r_crc16;
        n_crc32 = r_crc32;
        if (i_ctrl.load16) begin
            n_crc16 = i_ctrl.seed;
        end else if (i_ctrl.step16) begin
            n_crc16 = {r_crc16[14:0], 1'b0} ^ (w_fb16 ? CRC16_POLY : 16'd0);
        end
        if (i_ctrl.load32) begin
            n_crc32 = CRC32_INIT;
        end else if (i_ctrl.step32) begin
            n_crc32 = {1'b0, r_crc32[31:1]} ^ (w_fb32 ? CRC32_POLY : 32'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc16 <= 16'd0;
            r_crc32 <= CRC32_INIT;
        end else begin
            r_crc16 <= n_crc16;
            r_crc32 <= n_crc32;
        end
    end

    assign o_crc16 = r_crc16;
    assign o_crc32 = r_crc32;

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mrfdf_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 600;

    localparam int FILL_RANDOM  = 0;
    localparam int FILL_ZERO    = 1;
    localparam int FILL_ONES    = 2;
    localparam int FILL_GARBAGE = 3;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_HEADER,
        PH_PAYLOAD
    } t_parse_phase;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_data  = 16'h0000;

    t_in_item  rx_bits_q[$];
    t_out_item expected_bytes_q[$];

    int          mismatches = 0;
    int          cycles     = 0;
    int          frame_bits = 0;
    logic [15:0] seed_now   = 16'h0000;
    bit          quiet_end  = 1'b0;
    int          hold_reqs  = 0;
    int          hold_seen  = 0;
    int          hold_left  = 0;

    int in_gap      = 0;
    int in_stretch  = 0;
    bit in_bursty   = 1'b1;
    int out_gap     = 0;
    int out_stretch = 0;
    bit out_bursty  = 1'b1;

    t_parse_phase m_phase   = PH_SEARCH;
    logic [15:0]  m_hdr     = '0;
    logic [4:0]   m_hdr_cnt = '0;
    logic [7:0]   m_shift   = '0;
    logic [2:0]   m_bitpos  = '0;
    logic [11:0]  m_nbytes  = '0;
    logic [8:0]   m_pn9     = PN9_SEED;
    logic [15:0]  m_crc16   = '0;
    logic [31:0]  m_crc32   = CRC32_INIT;
    logic [31:0]  m_tail    = '0;
    logic [15:0]  m_seed    = '0;

    mrfsk_frame_deframer u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
        int i;
        crc = crc ^ {b, 8'h00};
        for (i = 0; i < 8; i++) begin
            crc = crc[15] ? ((crc << 1) ^ CRC16_POLY) : (crc << 1);
        end
        return crc;
    endfunction

    function automatic logic [31:0] crc32_update(logic [31:0] crc, logic [7:0] b);
        int i;
        crc = crc ^ {24'h000000, b};
        for (i = 0; i < 8; i++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC32_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

    // Returns the advanced register in the upper nine bits and the key byte below.
    function automatic logic [16:0] pn9_byte(logic [8:0] lfsr);
        logic [7:0] key;
        logic       fb;
        int         i;
        key = 8'h00;
        for (i = 0; i < 8; i++) begin
            fb = lfsr[0] ^ lfsr[5];
            key = {key[6:0], lfsr[0]};
            lfsr = {fb, lfsr[8:1]};
        end
        return {lfsr, key};
    endfunction

    task automatic deframe_bit(input t_in_item it, output logic made, output t_out_item res);
        logic [7:0]  b;
        logic [16:0] pn;
        int          n;
        made = 1'b0;
        res = '0;
        case (m_phase)
            PH_HEADER: begin
                m_hdr = {m_hdr[14:0], it.data_bit};
                m_hdr_cnt = m_hdr_cnt + 5'd1;
                if (m_hdr_cnt == HEADER_BITS) begin
                    if (m_hdr[12]) begin
                        m_crc16 = m_seed;
                    end else begin
                        m_crc32 = CRC32_INIT;
                    end
                    if (m_hdr[11]) begin
                        m_pn9 = PN9_SEED;
                    end
                    m_phase = PH_PAYLOAD;
                    m_bitpos = '0;
                    m_shift = '0;
                    m_nbytes = '0;
                    m_tail = '0;
                end
            end
            PH_PAYLOAD: begin
                m_shift = {m_shift[6:0], it.data_bit};
                if (m_bitpos != 3'd7) begin
                    m_bitpos = m_bitpos + 3'd1;
                end else begin
                    m_bitpos = '0;
                    b = m_shift;
                    if (m_hdr[11]) begin
                        pn = pn9_byte(m_pn9);
                        m_pn9 = pn[16:8];
                        b = b ^ pn[7:0];
                    end
                    m_shift = b;
                    if (m_hdr[12]) begin
                        m_crc16 = crc16_update(m_crc16, b);
                    end else if (m_nbytes + 4 < m_hdr[10:0]) begin
                        m_crc32 = crc32_update(m_crc32, b);
                    end
                    m_tail = {m_tail[23:0], b};
                    res.byte_value = b;
                    res.byte_index = m_nbytes[10:0];
                    res.header_word = m_hdr;
                    res.is_last = 1'b0;
                    res.frame_status = STATUS_BUSY;
                    m_nbytes = m_nbytes + 12'd1;
                    if (m_nbytes >= m_hdr[10:0]) begin
                        res.is_last = 1'b1;
                        if (m_hdr[12]) begin
                            res.frame_status = (m_crc16 == 16'h0000) ? STATUS_OK : STATUS_FAIL;
                        end else if (m_hdr[10:0] < 4) begin
                            res.frame_status = STATUS_FAIL;
                        end else begin
                            for (n = int'(m_nbytes); n < 8; n++) begin
                                m_crc32 = crc32_update(m_crc32, 8'h00);
                            end
                            res.frame_status = ((~m_crc32) == m_tail) ? STATUS_OK : STATUS_FAIL;
                        end
                        m_phase = PH_SEARCH;
                    end else if (m_nbytes >= MAX_FRAME_BYTES) begin
                        res.is_last = 1'b1;
                        res.frame_status = STATUS_OVERRUN;
                        m_phase = PH_SEARCH;
                    end
                    made = 1'b1;
                end
            end
            default: begin
                m_phase = PH_SEARCH;
                if (it.sync_flag) begin
                    m_hdr = {15'd0, it.data_bit};
                    m_hdr_cnt = 5'd1;
                    m_phase = PH_HEADER;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_out_item want;
        logic      made;
        if (!i_rst_n) begin
            m_phase = PH_SEARCH;
            m_hdr = '0;
            m_hdr_cnt = '0;
            m_shift = '0;
            m_bitpos = '0;
            m_nbytes = '0;
            m_pn9 = PN9_SEED;
            m_crc16 = '0;
            m_crc32 = CRC32_INIT;
            m_tail = '0;
            m_seed = '0;
        end else begin
            if (i_cfg_we) begin
                m_seed = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                deframe_bit(i_in_item, made, want);
                if (made) begin
                    expected_bytes_q.push_back(want);
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_bytes_q.size() == 0) begin
                    $display("%0t: unexpected output transaction, expected none, got %h",
                             $time, o_out_item);
                    mismatches++;
                end else begin
                    want = expected_bytes_q.pop_front();
                    check_field("byte_value", 16'(want.byte_value),
                                16'(o_out_item.byte_value));
                    check_field("byte_index", 16'(want.byte_index),
                                16'(o_out_item.byte_index));
                    check_field("header_word", want.header_word, o_out_item.header_word);
                    check_field("is_last", 16'(want.is_last), 16'(o_out_item.is_last));
                    check_field("frame_status", 16'(want.frame_status),
                                16'(o_out_item.frame_status));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in_item <= '0;
            in_gap <= 0;
        end else begin
            if (in_stretch == 0) begin
                in_bursty <= ($urandom_range(2, 0) != 0);
                in_stretch <= $urandom_range(200, 20);
            end else begin
                in_stretch <= in_stretch - 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap != 0) begin
                    i_in_valid <= 1'b0;
                    in_gap <= in_gap - 1;
                end else if (rx_bits_q.size() != 0 &&
                             !(in_bursty && !quiet_end && $urandom_range(7, 0) == 0)) begin
                    i_in_valid <= 1'b1;
                    i_in_item <= rx_bits_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                    if (rx_bits_q.size() != 0) begin
                        in_gap <= $urandom_range(6, 0);
                    end
                end
            end
        end
    end

    // A long receiver hold-off lets the block fill up and stall its input.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            out_gap <= 0;
        end else begin
            if (out_stretch == 0) begin
                out_bursty <= ($urandom_range(2, 0) != 0);
                out_stretch <= $urandom_range(200, 20);
            end else begin
                out_stretch <= out_stretch - 1;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
            end else if (out_gap != 0) begin
                i_out_stall <= 1'b1;
                out_gap <= out_gap - 1;
            end else if (out_bursty && !quiet_end && $urandom_range(7, 0) == 0) begin
                i_out_stall <= 1'b1;
                out_gap <= $urandom_range(6, 0);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic push_bit(input logic b, input logic s);
        t_in_item it;
        it.data_bit = b;
        it.sync_flag = s;
        rx_bits_q.push_back(it);
    endtask

    task automatic push_noise(input int n);
        int i;
        for (i = 0; i < n; i++) begin
            push_bit(1'($urandom_range(1, 0)), 1'b0);
        end
    endtask

    task automatic push_frame(input int flen, input bit whiten, input bit short_fcs,
                              input bit corrupt, input int fill);
        logic [7:0]  body[$];
        logic [15:0] hdr;
        logic [15:0] c16;
        logic [31:0] c32;
        logic [8:0]  lfsr;
        logic [16:0] pn;
        logic [7:0]  tx;
        int          nbytes;
        int          i;
        int          k;
        hdr = {3'($urandom_range(7, 0)), short_fcs, whiten, 11'(flen)};
        nbytes = (flen == 0) ? 1 : flen;
        for (i = 0; i < nbytes; i++) begin
            case (fill)
                FILL_ZERO: body.push_back(8'h00);
                FILL_ONES: body.push_back(8'hFF);
                default:   body.push_back(8'($urandom));
            endcase
        end
        if (fill != FILL_GARBAGE) begin
            if (short_fcs && flen >= 2) begin
                c16 = seed_now;
                for (i = 0; i < flen - 2; i++) begin
                    c16 = crc16_update(c16, body[i]);
                end
                body[flen - 2] = c16[15:8];
                body[flen - 1] = c16[7:0];
            end else if (!short_fcs && flen >= 4) begin
                c32 = CRC32_INIT;
                for (i = 0; i < flen - 4; i++) begin
                    c32 = crc32_update(c32, body[i]);
                end
                for (k = flen; k < 8; k++) begin
                    c32 = crc32_update(c32, 8'h00);
                end
                c32 = ~c32;
                for (i = 0; i < 4; i++) begin
                    body[flen - 4 + i] = c32[31 - 8 * i -: 8];
                end
            end
        end
        if (corrupt) begin
            k = $urandom_range(nbytes - 1, 0);
            body[k] = body[k] ^ (8'h01 << $urandom_range(7, 0));
        end
        for (i = 15; i >= 0; i--) begin
            push_bit(hdr[i], (i == 15) ? 1'b1 : ($urandom_range(3, 0) == 0));
        end
        lfsr = PN9_SEED;
        for (i = 0; i < nbytes; i++) begin
            tx = body[i];
            if (whiten) begin
                pn = pn9_byte(lfsr);
                lfsr = pn[16:8];
                tx = tx ^ pn[7:0];
            end
            for (k = 7; k >= 0; k--) begin
                push_bit(tx[k], $urandom_range(3, 0) == 0);
            end
        end
        frame_bits += 16 + 8 * nbytes;
    endtask

    task automatic push_random_frames(input int count);
        int target;
        int roll;
        int flen;
        int kind;
        target = frame_bits + count;
        while (frame_bits < target) begin
            roll = $urandom_range(99, 0);
            if (roll < 80) begin
                flen = $urandom_range(16, 0);
            end else if (roll < 95) begin
                flen = $urandom_range(64, 17);
            end else begin
                flen = $urandom_range(200, 65);
            end
            kind = $urandom_range(99, 0);
            push_frame(flen, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                       (kind >= 80 && kind < 92), (kind >= 92) ? FILL_GARBAGE : FILL_RANDOM);
            push_noise($urandom_range(4, 0));
        end
    endtask

    task automatic drain_and_settle();
        while (!(rx_bits_q.size() == 0 && !i_in_valid && expected_bytes_q.size() == 0)) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [15:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        seed_now = value;
        @(negedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        push_noise(5);
        push_frame(0, 1'b0, 1'b1, 1'b0, FILL_RANDOM);
        push_frame(0, 1'b1, 1'b0, 1'b0, FILL_RANDOM);
        push_noise(3);
        push_frame(1, 1'b0, 1'b0, 1'b0, FILL_RANDOM);
        push_frame(3, 1'b1, 1'b0, 1'b0, FILL_RANDOM);
        push_frame(4, 1'b0, 1'b0, 1'b0, FILL_RANDOM);
        push_frame(7, 1'b1, 1'b0, 1'b0, FILL_RANDOM);
        push_frame(8, 1'b0, 1'b0, 1'b0, FILL_RANDOM);
        push_frame(2, 1'b0, 1'b1, 1'b0, FILL_RANDOM);
        push_frame(5, 1'b1, 1'b1, 1'b0, FILL_RANDOM);
        push_frame(6, 1'b0, 1'b1, 1'b1, FILL_RANDOM);
        push_frame(6, 1'b0, 1'b1, 1'b0, FILL_ZERO);
        push_frame(10, 1'b1, 1'b0, 1'b0, FILL_ONES);
        push_frame(9, 1'b0, 1'b0, 1'b1, FILL_RANDOM);
        push_noise(4);
        drain_and_settle();

        write_seed(16'hFFFF);
        push_frame(3, 1'b0, 1'b1, 1'b0, FILL_RANDOM);
        push_frame(12, 1'b1, 1'b1, 1'b0, FILL_RANDOM);
        push_frame(12, 1'b0, 1'b1, 1'b1, FILL_ONES);
        push_frame(1, 1'b1, 1'b1, 1'b0, FILL_ZERO);
        drain_and_settle();

        write_seed(16'($urandom));
        push_random_frames(250);
        hold_reqs++;
        drain_and_settle();

        write_seed(16'h0000);
        push_frame(24, 1'b1, 1'b1, 1'b0, FILL_RANDOM);
        push_frame(5, 1'b0, 1'b1, 1'b0, FILL_RANDOM);
        drain_and_settle();

        write_seed(16'($urandom));
        quiet_end = 1'b1;
        push_random_frames(60);
        drain_and_settle();

        if (mismatches == 0 && expected_bytes_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
